// ===== hw/rtl/multi_buffer_ring_manager_assert.svh =====
// Assertion macros for the ring manager.
`ifndef MULTI_BUFFER_RING_MANAGER_ASSERT_SVH
`define MULTI_BUFFER_RING_MANAGER_ASSERT_SVH

`ifndef SYNTH

// Clocked assertion, disabled while reset is asserted.
`define MBRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define MBRM_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define MBRM_ASSERT(lbl, prop, msg)
`define MBRM_ASSERT_NR(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/mbrm_pkg.sv =====
package mbrm_pkg;

  localparam logic [1:0] REQ_COMMIT = 2'd0;
  localparam logic [1:0] REQ_TAKE   = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [15:0] BUF_SIZE_RST = 16'd4096;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] byte_count;
  } in_t;

  typedef struct packed {
    logic [3:0]  write_buffer;
    logic [15:0] write_offset;
    logic [15:0] write_space;
    logic [3:0]  read_buffer;
    logic [15:0] read_fill;
    logic [3:0]  ready_buffers;
    logic        buffer_completed;
    logic        read_granted;
    logic        overflow_error;
  } out_t;

endpackage

// ===== hw/rtl/mbrm_ram.sv =====
module mbrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

// ===== hw/rtl/multi_buffer_ring_manager.sv =====
// Channel | Dir | Payload              | Handshake
// --------+-----+----------------------+------------------------------------
// in      | in  | in_data_i  (in_t)    | in_valid_i / in_stall_o
// out     | out | out_data_o (out_t)   | out_valid_o / out_stall_i
// cfg     | in  | cfg_data_i (16 bit)  | cfg_we_i, buffer_size
//
// One request per cycle sustained while in_stall_o is low. Once a request is
// taken, its result is registered into the output or skid entry when there is
// room: state updates and the fill RAM's registered read of the new slots
// happen at the taking edge. in_stall_o rises only when a result is pending
// and the skid entry is also held. Reset clears the per-buffer valid bits so
// every fill reads zero at once; no clearing pass is needed.
`include "multi_buffer_ring_manager_assert.svh"

module multi_buffer_ring_manager
  import mbrm_pkg::*;
#(
  parameter int NUM_BUFFERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam logic [IW-1:0] LAST = IW'(NUM_BUFFERS - 1);

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  // Ring state
  logic [15:0]            bsize_q;
  logic [IW-1:0]          wr_idx_q, wr_idx_d;
  logic [IW-1:0]          rd_idx_q, rd_idx_d;
  logic [IW-1:0]          full_q, full_d;
  logic                   ovf_q, ovf_d;
  logic [NUM_BUFFERS-1:0] valid_q, valid_d;

  // Fill RAM access and forwarding
  logic          we;
  logic [IW-1:0] waddr;
  logic [15:0]   wdata;
  logic [15:0]   ram_rd0, ram_rd1;
  logic          byp_w_q, byp_r_q, vld_w_q, vld_r_q;
  logic [15:0]   byp_data_q;
  logic [15:0]   wfill, rfill;

  // Step control
  logic        acc;
  logic [16:0] sum;
  logic        step_cmp, step_gnt;

  // Result path
  logic pend_q, pend_cmp_q, pend_gnt_q;
  logic out_vld_q, skid_vld_q;
  out_t out_q, skid_q, res;
  logic take, push;

  mbrm_ram #(
    .WIDTH(16),
    .DEPTH(NUM_BUFFERS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr0_i(wr_idx_d),
    .raddr1_i(rd_idx_d),
    .rdata0_o(ram_rd0),
    .rdata1_o(ram_rd1)
  );

  assign wfill = byp_w_q ? byp_data_q : (vld_w_q ? ram_rd0 : '0);
  assign rfill = byp_r_q ? byp_data_q : (vld_r_q ? ram_rd1 : '0);

  assign in_stall_o = pend_q && skid_vld_q;
  assign acc        = in_valid_i && !in_stall_o;
  assign sum        = {1'b0, wfill} + {1'b0, in_data_i.byte_count};

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    full_d   = full_q;
    ovf_d    = ovf_q;
    valid_d  = valid_q;
    we       = 1'b0;
    waddr    = wr_idx_q;
    wdata    = sum[15:0];
    step_cmp = 1'b0;
    step_gnt = 1'b0;
    if (acc) begin
      case (in_data_i.req_type)
        REQ_COMMIT: begin
          if (sum > {1'b0, bsize_q}) begin
            ovf_d = 1'b1;
          end else if (in_data_i.byte_count != '0) begin
            we = 1'b1;
            if (sum[15:0] == bsize_q) begin
              wr_idx_d = next_slot(wr_idx_q);
              if (full_q != LAST) begin
                full_d = full_q + 1'b1;
              end
              step_cmp = 1'b1;
            end
          end
        end
        REQ_TAKE: begin
          if (full_q != '0) begin
            we       = 1'b1;
            waddr    = rd_idx_q;
            wdata    = '0;
            full_d   = full_q - 1'b1;
            rd_idx_d = next_slot(rd_idx_q);
            step_gnt = 1'b1;
          end
        end
        REQ_FLUSH: begin
          wr_idx_d = rd_idx_q;
          full_d   = LAST;
        end
        REQ_CLEAR: begin
          ovf_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (we) begin
      valid_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q  <= BUF_SIZE_RST;
      wr_idx_q <= '0;
      rd_idx_q <= LAST;
      full_q   <= '0;
      ovf_q    <= 1'b0;
      valid_q  <= '0;
      byp_w_q  <= 1'b0;
      byp_r_q  <= 1'b0;
      vld_w_q  <= 1'b0;
      vld_r_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bsize_q <= cfg_data_i;
      end
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      full_q   <= full_d;
      ovf_q    <= ovf_d;
      valid_q  <= valid_d;
      // Forward this cycle's write past the RAM's read-before-write port
      byp_w_q  <= we && (waddr == wr_idx_d);
      byp_r_q  <= we && (waddr == rd_idx_d);
      vld_w_q  <= valid_q[wr_idx_d];
      vld_r_q  <= valid_q[rd_idx_d];
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
  end

  // Result reflects the state left by the pending transaction
  always_comb begin
    res.write_buffer     = 4'(wr_idx_q);
    res.write_offset     = wfill;
    res.write_space      = ((wr_idx_q == rd_idx_q) || (wfill >= bsize_q)) ? '0
                                                                           : bsize_q - wfill;
    res.read_buffer      = 4'(rd_idx_q);
    res.read_fill        = rfill;
    res.ready_buffers    = 4'(full_q);
    res.buffer_completed = pend_cmp_q;
    res.read_granted     = pend_gnt_q;
    res.overflow_error   = ovf_q;
  end

  assign take = out_vld_q && !out_stall_i;
  assign push = pend_q && (take || !skid_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        pend_q <= 1'b1;
      end else if (push) begin
        pend_q <= 1'b0;
      end
      if (take) begin
        if (skid_vld_q) begin
          skid_vld_q <= push;
        end else begin
          out_vld_q <= push;
        end
      end else if (push) begin
        if (!out_vld_q) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pend_cmp_q <= step_cmp;
      pend_gnt_q <= step_gnt;
    end
    if (take) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= res;
        end
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      if (!out_vld_q) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `MBRM_ASSERT_NR(a_skid_needs_out, skid_vld_q |-> out_vld_q, "skid without output entry")
  `MBRM_ASSERT(a_commit_advances, step_cmp |=> (wr_idx_q != $past(wr_idx_q)), "no advance")
  `MBRM_ASSERT(a_take_decrements, step_gnt |=> (full_q == $past(full_q) - 1'b1), "no decrement")

endmodule

// ===== verif/mbrm_ring_checker.sv =====
module mbrm_ring_checker
  import mbrm_pkg::*;
#(
  parameter int NUM_BUFFERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output int          err_count_o,
  output int          pending_o
);

  logic [15:0] buf_size;
  int          wr_idx;
  int          rd_idx;
  int          full_cnt;
  logic [15:0] fill [NUM_BUFFERS];
  logic        ovf;

  out_t        status_q [$];
  out_t        exp_status;
  int          errs;

  function automatic int next_slot(int i);
    return (i == NUM_BUFFERS - 1) ? 0 : i + 1;
  endfunction

  // Update the shadow ring for one request and return the status it leaves.
  function automatic out_t apply_request(in_t rq);
    out_t        st;
    logic [16:0] sum;
    logic        completed;
    logic        granted;
    completed = 1'b0;
    granted   = 1'b0;
    case (rq.req_type)
      REQ_COMMIT: begin
        sum = {1'b0, fill[wr_idx]} + {1'b0, rq.byte_count};
        if (sum > {1'b0, buf_size}) begin
          ovf = 1'b1;
        end else if (rq.byte_count != 16'd0) begin
          fill[wr_idx] = sum[15:0];
          if (fill[wr_idx] == buf_size) begin
            wr_idx = next_slot(wr_idx);
            if (full_cnt < NUM_BUFFERS - 1) full_cnt++;
            completed = 1'b1;
          end
        end
      end
      REQ_TAKE: begin
        if (full_cnt > 0) begin
          fill[rd_idx] = '0;
          full_cnt--;
          rd_idx  = next_slot(rd_idx);
          granted = 1'b1;
        end
      end
      REQ_FLUSH: begin
        wr_idx   = rd_idx;
        full_cnt = NUM_BUFFERS - 1;
      end
      default: begin
        ovf = 1'b0;
      end
    endcase
    st.write_buffer  = wr_idx[3:0];
    st.write_offset  = fill[wr_idx];
    // no space is offered while the writer sits on the read slot
    if (wr_idx == rd_idx || fill[wr_idx] >= buf_size) st.write_space = '0;
    else st.write_space = buf_size - fill[wr_idx];
    st.read_buffer      = rd_idx[3:0];
    st.read_fill        = fill[rd_idx];
    st.ready_buffers    = full_cnt[3:0];
    st.buffer_completed = completed;
    st.read_granted     = granted;
    st.overflow_error   = ovf;
    return st;
  endfunction

  function automatic string fmt(out_t s);
    return $sformatf("wb=%0d wo=%0d ws=%0d rb=%0d rf=%0d rdy=%0d cmp=%0b gnt=%0b ovf=%0b",
                     s.write_buffer, s.write_offset, s.write_space, s.read_buffer,
                     s.read_fill, s.ready_buffers, s.buffer_completed,
                     s.read_granted, s.overflow_error);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size = BUF_SIZE_RST;
      wr_idx   = 0;
      rd_idx   = NUM_BUFFERS - 1;
      full_cnt = 0;
      ovf      = 1'b0;
      foreach (fill[i]) fill[i] = '0;
      status_q.delete();
      errs = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      // check the output first: a result never belongs to a same-edge request
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("%0t: unexpected result %s", $time, fmt(out_data_i));
        end else begin
          exp_status = status_q.pop_front();
          if (out_data_i !== exp_status) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: status mismatch", $time);
              $display("  expected %s", fmt(exp_status));
              $display("  actual   %s", fmt(out_data_i));
            end
          end
        end
      end
      if (cfg_we_i) buf_size = cfg_data_i;
      if (in_valid_i && !in_stall_i) status_q.push_back(apply_request(in_data_i));
      err_count_o <= errs;
      pending_o   <= status_q.size();
    end
  end

endmodule

// ===== verif/tb_multi_buffer_ring_manager.sv =====
module tb_multi_buffer_ring_manager;
  import mbrm_pkg::*;

  localparam int NUM_BUFFERS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 210;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_data_i  = '0;

  int          err_count;
  int          pending;
  int          cycle_cnt   = 0;
  bit          no_gaps     = 1'b0;
  bit          hold_req    = 1'b0;

  always #5 clk_i = ~clk_i;

  multi_buffer_ring_manager #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  mbrm_ring_checker #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) ring_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_i (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !no_gaps && ($urandom_range(99) < 8);
      end
    end
  end

  task automatic send_req(logic [1:0] op, logic [15:0] cnt);
    while (!no_gaps && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{req_type: op, byte_count: cnt};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold requests until every outstanding transaction has produced its result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_buf_size(logic [15:0] sz);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= sz;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int          sz;
    int          chunk;
    int          d;
    int          r;
    logic [1:0]  op;
    logic [15:0] cnt;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset size, overflow, refusal, flush, saturation
    send_req(REQ_COMMIT, 16'd0);
    send_req(REQ_TAKE,   16'd0);
    send_req(REQ_COMMIT, 16'd4096);
    send_req(REQ_COMMIT, 16'hFFFF);
    send_req(REQ_CLEAR,  16'd0);
    send_req(REQ_TAKE,   16'd0);
    send_req(REQ_TAKE,   16'd0);
    send_req(REQ_FLUSH,  16'd0);
    send_req(REQ_COMMIT, 16'd100);
    send_req(REQ_COMMIT, 16'd3996);
    send_req(REQ_TAKE,   16'd0);
    send_req(REQ_COMMIT, 16'd1000);
    drain();
    // shrink below the current fill
    set_buf_size(16'd500);
    send_req(REQ_COMMIT, 16'd0);
    send_req(REQ_COMMIT, 16'd1);
    send_req(REQ_CLEAR,  16'd0);
    drain();
    set_buf_size(16'd0);
    send_req(REQ_COMMIT, 16'd5);
    send_req(REQ_COMMIT, 16'd0);
    send_req(REQ_CLEAR,  16'd0);
    drain();
    set_buf_size(16'hFFFF);
    send_req(REQ_COMMIT, 16'd64535);
    send_req(REQ_COMMIT, 16'hFFFF);
    send_req(REQ_COMMIT, 16'd1);
    send_req(REQ_COMMIT, 16'hFFFF);
    send_req(REQ_CLEAR,  16'd0);
    drain();
    set_buf_size(16'd1);
    send_req(REQ_COMMIT, 16'd1);
    send_req(REQ_TAKE,   16'd0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       sz = 1;
        1:       sz = 2;
        2:       sz = 4096;
        3:       sz = 65535;
        4:       sz = $urandom_range(2, 200);
        6:       sz = 7;
        default: sz = $urandom_range(1, 65535);
      endcase
      // commit in whole fractions of the buffer so buffers fill exactly
      d = $urandom_range(1, 16);
      while (sz % d != 0) d--;
      chunk = sz / d;
      set_buf_size(sz[15:0]);
      no_gaps  <= (phase == 4);
      hold_req <= (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 5 && n == PHASE_ITEMS / 2) drain();
        r = $urandom_range(99);
        if (r < 58)      op = REQ_COMMIT;
        else if (r < 83) op = REQ_TAKE;
        else if (r < 88) op = REQ_FLUSH;
        else             op = REQ_CLEAR;
        r = $urandom_range(99);
        if (r < 70)      cnt = chunk[15:0];
        else if (r < 80) cnt = 16'd0;
        else if (r < 90) cnt = 16'($urandom_range(0, sz));
        else             cnt = 16'($urandom());
        // non-commit requests ignore the count, so let it wander freely
        if (op != REQ_COMMIT) cnt = 16'($urandom());
        send_req(op, cnt);
      end
      drain();
    end

    no_gaps <= 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
